FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the heater guard.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("heater guard check failed");

// Condition must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("heater guard forbidden condition seen");

`endif

FILE: rtl/hbbg_pkg.sv
// Package for the heater bang-bang guard: command codes, fixed limits and
// the result type passed from the control core to the top level.
// No dependencies.
package hbbg_pkg;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FAULT  = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MAX_TEMP   = 3'd0;
  localparam logic [2:0] REG_TARGET     = 3'd1;
  localparam logic [2:0] REG_TOLERANCE  = 3'd2;
  localparam logic [2:0] REG_TARGET_EN  = 3'd3;
  localparam logic [2:0] REG_CHANGE_THR = 3'd4;

  // Register reset values
  localparam logic [12:0]        MAX_TEMP_RST   = 13'd4000;
  localparam logic signed [13:0] TARGET_RST     = 14'sd0;
  localparam logic [10:0]        TOLERANCE_RST  = 11'd16;
  localparam logic [10:0]        CHANGE_THR_RST = 11'd8;

  // Fixed limits in 1/16 degree units
  localparam logic signed [15:0] TEMP_LOW_LIMIT  = -16'sd800;
  localparam logic signed [15:0] TEMP_HIGH_LIMIT = 16'sd8000;
  localparam logic [6:0]         CLEAR_HYST      = 7'd80;

  // Configuration seen by the core
  typedef struct packed {
    logic [12:0]        max_temp;
    logic signed [13:0] target_temp;
    logic [10:0]        tolerance;
    logic               target_enable;
    logic [10:0]        change_threshold;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic heater_on;
    logic fault_latched;
    logic fault_event;
    logic changed_event;
    logic reached_event;
    logic on_event;
    logic off_event;
  } result_t;

endpackage

FILE: rtl/hbbg_core.sv
// Control core of the heater guard: state registers and the single-pass
// sample, fault and bang-bang logic. Depends on hbbg_pkg.
module hbbg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,     // item in the input register moves on
  input  logic              clear_mark,  // target registers written
  input  hbbg_pkg::cfg_t    cfg,
  input  logic [1:0]        cmd,
  input  logic signed [15:0] temperature,
  input  logic              sample_invalid,
  output hbbg_pkg::result_t result
);

  // State
  logic signed [15:0] last_temp, last_temp_next;
  logic have_last, have_last_next;
  logic fault_flag, fault_flag_next;
  logic relay_state, relay_state_next;
  logic reached_mark, reached_mark_next;

  // Widened operands for exact compares
  logic signed [17:0] t18, last18, diff18, maxt18, clr18, lo18, hi18;
  logic [17:0] abs_diff;
  logic out_of_range, below_lo, above_hi;

  always_comb begin
    t18    = {{2{temperature[15]}}, temperature};
    last18 = {{2{last_temp[15]}}, last_temp};
    diff18 = t18 - last18;
    abs_diff = diff18[17] ? 18'(-diff18) : 18'(diff18);
    maxt18 = {5'b0, cfg.max_temp};
    clr18  = maxt18 - {11'b0, hbbg_pkg::CLEAR_HYST};
    lo18   = {{4{cfg.target_temp[13]}}, cfg.target_temp} - {7'b0, cfg.tolerance};
    hi18   = {{4{cfg.target_temp[13]}}, cfg.target_temp} + {7'b0, cfg.tolerance};
    out_of_range = (t18 >= maxt18)
                || (temperature < hbbg_pkg::TEMP_LOW_LIMIT)
                || (temperature > hbbg_pkg::TEMP_HIGH_LIMIT);
    below_lo = t18 < lo18;
    above_hi = t18 >= hi18;
  end

  // Next state and event pulses for the current item
  always_comb begin
    last_temp_next    = last_temp;
    have_last_next    = have_last;
    fault_flag_next   = fault_flag;
    relay_state_next  = relay_state;
    reached_mark_next = reached_mark;
    result = '0;

    case (hbbg_pkg::cmd_t'(cmd))
      hbbg_pkg::CMD_SAMPLE: begin
        if (sample_invalid) begin
          result.changed_event = !have_last;
          have_last_next   = 1'b0;
          fault_flag_next  = 1'b1;
          relay_state_next = 1'b0;
          result.off_event   = relay_state;
          result.fault_event = 1'b1;
        end else begin
          result.changed_event = !have_last || (abs_diff > {7'b0, cfg.change_threshold});
          last_temp_next = temperature;
          have_last_next = 1'b1;
          if (out_of_range) begin
            fault_flag_next  = 1'b1;
            relay_state_next = 1'b0;
            result.off_event   = relay_state;
            result.fault_event = 1'b1;
          end else begin
            // hysteresis release, then control on the same sample
            if (fault_flag && (t18 < clr18)) begin
              fault_flag_next = 1'b0;
            end
            if (!fault_flag_next && cfg.target_enable) begin
              if (below_lo) begin
                relay_state_next = 1'b1;
                result.on_event  = !relay_state;
              end else if (above_hi) begin
                relay_state_next = 1'b0;
                result.off_event = relay_state;
              end
              if (relay_state_next && !below_lo && (t18 <= hi18) && !reached_mark) begin
                reached_mark_next    = 1'b1;
                result.reached_event = 1'b1;
              end else if (below_lo) begin
                reached_mark_next = 1'b0;
              end
            end
          end
        end
      end
      hbbg_pkg::CMD_FAULT: begin
        fault_flag_next  = 1'b1;
        relay_state_next = 1'b0;
        result.off_event   = relay_state;
        result.fault_event = 1'b1;
      end
      hbbg_pkg::CMD_START: begin
        if (!fault_flag) begin
          relay_state_next = 1'b1;
          result.on_event  = !relay_state;
        end
      end
      default: begin
        relay_state_next = 1'b0;
        result.off_event = relay_state;
      end
    endcase

    result.heater_on     = relay_state_next;
    result.fault_latched = fault_flag_next;
  end

  // State update, one item per cycle while advance is high
  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp    <= '0;
      have_last    <= 1'b0;
      fault_flag   <= 1'b0;
      relay_state  <= 1'b0;
      reached_mark <= 1'b0;
    end else begin
      if (advance) begin
        last_temp   <= last_temp_next;
        have_last   <= have_last_next;
        fault_flag  <= fault_flag_next;
        relay_state <= relay_state_next;
      end
      if (clear_mark) begin
        reached_mark <= 1'b0;
      end else if (advance) begin
        reached_mark <= reached_mark_next;
      end
    end
  end

endmodule

FILE: rtl/heater_bang_bang_guard_unit.sv
// Top level of the heater bang-bang guard: stream ports, APB register file,
// input and output registers around hbbg_core. Depends on hbbg_pkg, hbbg_core.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    tdata: temperature; tuser: cmd, invalid
//  m_*       out        m_tvalid/m_tready    tdata: relay, fault and event flags
//  apb       in         psel/penable/pready  5 registers at byte address 4*i
//
// An item passes through the input register and then sits in the output
// register until taken; one item per cycle is sustained while m_tready is high.
// The output register holds while m_tready is low; the input register then
// holds one more item and s_tready drops. rst is synchronous and clears the
// state, the valid flags and the registers to their reset values.
module heater_bang_bang_guard_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] temperature
  input  logic [2:0]  s_tuser,   // [1:0] cmd, [2] sample_invalid
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] heater_on, [1] fault_latched, [2] fault_event,
                                 // [3] changed_event, [4] reached_event,
                                 // [5] on_event, [6] off_event, [7] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hbbg_pkg::cfg_t    cfg;
  hbbg_pkg::result_t result;

  logic        in_valid;
  logic [1:0]  in_cmd;
  logic signed [15:0] in_temp;
  logic        in_invalid;
  logic        advance, s_accept, cfg_write, clear_mark;
  logic [2:0]  reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign clear_mark = cfg_write && ((reg_index == hbbg_pkg::REG_TARGET)
                                 || (reg_index == hbbg_pkg::REG_TOLERANCE)
                                 || (reg_index == hbbg_pkg::REG_TARGET_EN));

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_temp         <= hbbg_pkg::MAX_TEMP_RST;
      cfg.target_temp      <= hbbg_pkg::TARGET_RST;
      cfg.tolerance        <= hbbg_pkg::TOLERANCE_RST;
      cfg.target_enable    <= 1'b0;
      cfg.change_threshold <= hbbg_pkg::CHANGE_THR_RST;
    end else if (cfg_write) begin
      case (reg_index)
        hbbg_pkg::REG_MAX_TEMP:   cfg.max_temp         <= pwdata[12:0];
        hbbg_pkg::REG_TARGET:     cfg.target_temp      <= pwdata[13:0];
        hbbg_pkg::REG_TOLERANCE:  cfg.tolerance        <= pwdata[10:0];
        hbbg_pkg::REG_TARGET_EN:  cfg.target_enable    <= pwdata[0];
        hbbg_pkg::REG_CHANGE_THR: cfg.change_threshold <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_index)
      hbbg_pkg::REG_MAX_TEMP:   prdata = {19'b0, cfg.max_temp};
      hbbg_pkg::REG_TARGET:     prdata = {{18{cfg.target_temp[13]}}, cfg.target_temp};
      hbbg_pkg::REG_TOLERANCE:  prdata = {21'b0, cfg.tolerance};
      hbbg_pkg::REG_TARGET_EN:  prdata = {31'b0, cfg.target_enable};
      hbbg_pkg::REG_CHANGE_THR: prdata = {21'b0, cfg.change_threshold};
      default:                  prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the output slot frees
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_temp    <= s_tdata;
      in_cmd     <= s_tuser[1:0];
      in_invalid <= s_tuser[2];
    end
  end

  hbbg_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .clear_mark     (clear_mark),
    .cfg            (cfg),
    .cmd            (in_cmd),
    .temperature    (in_temp),
    .sample_invalid (in_invalid),
    .result         (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, result.off_event, result.on_event, result.reached_event,
                  result.changed_event, result.fault_event, result.fault_latched,
                  result.heater_on};
    end
  end

endmodule

FILE: rtl/hbbg_checker.sv
// Port-level checks for the heater guard, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hbbg_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A latched fault always means the relay is off
  `CHK_NEVER(a_fault_relay_off, clk, rst, m_tvalid && m_tdata[1] && m_tdata[0])
  // A fault raised by this item is latched after it
  `CHK_NEVER(a_fault_event_latched, clk, rst, m_tvalid && m_tdata[2] && !m_tdata[1])
  // Switch events agree with the relay level
  `CHK_NEVER(a_on_event_level, clk, rst, m_tvalid && m_tdata[5] && !m_tdata[0])
  `CHK_NEVER(a_off_event_level, clk, rst, m_tvalid && m_tdata[6] && m_tdata[0])
  // A stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind heater_bang_bang_guard_unit hbbg_checker u_hbbg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/heater_bang_bang_guard_unit_test.sv
// Self-checking testbench for heater_bang_bang_guard_unit: stream items in,
// relay and event flags out, checked against an in-bench thermostat predictor.
// Depends on hbbg_pkg and the heater_bang_bang_guard_unit RTL.
`timescale 1ns / 100ps

module heater_bang_bang_guard_unit_test;

  localparam logic [2:0] REG_SPARE  = 3'd5;  // unmapped index, writes do nothing
  localparam int         IDLE_LIMIT = 1000;
  localparam int         SHOWN_MAX  = 10;

  typedef enum {RX_ALWAYS, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] temperature
  logic [2:0]  s_tuser;   // [1:0] cmd, [2] sample_invalid
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] heater_on, [1] fault_latched, [2] fault_event,
                          // [3] changed_event, [4] reached_event, [5] on_event,
                          // [6] off_event, [7] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and the controller state
  hbbg_pkg::cfg_t     cfg;
  logic signed [15:0] last_temp;
  logic               have_last;
  logic               fault_q;
  logic               relay_q;
  logic               reached_q;

  hbbg_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  int      plant_temp = 0;
  bit      free_run = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_len = 0;

  string field_name [8] = '{"heater_on", "fault_latched", "fault_event", "changed_event",
                            "reached_event", "on_event", "off_event", "pad"};

  heater_bang_bang_guard_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void relay_set(input logic on, inout hbbg_pkg::result_t r);
    if (on && !relay_q) begin
      relay_q = 1'b1;
      r.on_event = 1'b1;
    end else if (!on && relay_q) begin
      relay_q = 1'b0;
      r.off_event = 1'b1;
    end
  endfunction

  function automatic void fault_raise(inout hbbg_pkg::result_t r);
    fault_q = 1'b1;
    relay_set(1'b0, r);
    r.fault_event = 1'b1;
  endfunction

  // One item through the thermostat: change check, cutout, bang-bang band
  function automatic hbbg_pkg::result_t thermostat_step(hbbg_pkg::cmd_t c,
                                                        logic signed [15:0] temp,
                                                        logic inv);
    hbbg_pkg::result_t r;
    int t, d, thr, maxt, lo, hi, tgt, tol, low_lim, high_lim, hyst;
    r        = '0;
    t        = temp;
    thr      = cfg.change_threshold;
    maxt     = cfg.max_temp;
    tgt      = $signed(cfg.target_temp);
    tol      = cfg.tolerance;
    low_lim  = hbbg_pkg::TEMP_LOW_LIMIT;
    high_lim = hbbg_pkg::TEMP_HIGH_LIMIT;
    hyst     = hbbg_pkg::CLEAR_HYST;
    case (c)
      hbbg_pkg::CMD_SAMPLE: begin
        if (inv) begin
          r.changed_event = !have_last;
          have_last = 1'b0;
          fault_raise(r);
        end else begin
          d = t - last_temp;
          if (d < 0) d = -d;
          r.changed_event = !have_last || (d > thr);
          last_temp = temp;
          have_last = 1'b1;
          if (t >= maxt || t < low_lim || t > high_lim) begin
            fault_raise(r);
          end else begin
            // a clearing sample runs control right away
            if (fault_q && t < maxt - hyst) fault_q = 1'b0;
            if (!fault_q && cfg.target_enable) begin
              lo = tgt - tol;
              hi = tgt + tol;
              if (t < lo) relay_set(1'b1, r);
              else if (t >= hi) relay_set(1'b0, r);
              if (relay_q && t >= lo && t <= hi && !reached_q) begin
                reached_q = 1'b1;
                r.reached_event = 1'b1;
              end else if (t < lo) begin
                reached_q = 1'b0;
              end
            end
          end
        end
      end
      hbbg_pkg::CMD_FAULT: fault_raise(r);
      hbbg_pkg::CMD_START: if (!fault_q) relay_set(1'b1, r);
      default:   relay_set(1'b0, r);
    endcase
    r.heater_on     = relay_q;
    r.fault_latched = fault_q;
    return r;
  endfunction

  function automatic void cfg_apply(logic [2:0] idx, logic [31:0] v);
    case (idx)
      hbbg_pkg::REG_MAX_TEMP:   cfg.max_temp = v[12:0];
      hbbg_pkg::REG_TARGET: begin
        cfg.target_temp = v[13:0];
        reached_q = 1'b0;
      end
      hbbg_pkg::REG_TOLERANCE: begin
        cfg.tolerance = v[10:0];
        reached_q = 1'b0;
      end
      hbbg_pkg::REG_TARGET_EN: begin
        cfg.target_enable = v[0];
        reached_q = 1'b0;
      end
      hbbg_pkg::REG_CHANGE_THR: cfg.change_threshold = v[10:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // Drop valid and wait until every pending result has drained
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup then access; only while the block is idle
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_apply(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one item, in bursts with random gaps between them unless free_run is set
  task automatic send_item(hbbg_pkg::cmd_t c, logic signed [15:0] temp, logic inv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (free_run) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(0, 20);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= temp;
    s_tuser  <= {inv, c};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(thermostat_step(c, temp, inv));
  endtask

  // Mostly samples, some from a crude plant model that warms while the relay is on
  task automatic send_random_item();
    int pick, t, tol, tgt, maxt, span, step;
    hbbg_pkg::cmd_t c;
    logic inv;
    tol  = cfg.tolerance;
    tgt  = $signed(cfg.target_temp);
    maxt = cfg.max_temp;
    span = 2 * tol + 40;
    inv  = 1'b0;
    t    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) c = hbbg_pkg::CMD_START;
    else if (pick < 16) c = hbbg_pkg::CMD_STOP;
    else if (pick < 20) c = hbbg_pkg::CMD_FAULT;
    else begin
      c    = hbbg_pkg::CMD_SAMPLE;
      inv  = ($urandom_range(0, 99) < 4);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        step = $urandom_range(0, tol / 2 + 8);
        plant_temp = relay_q ? plant_temp + step : plant_temp - step;
        if (plant_temp > 8300) plant_temp = 8300;
        if (plant_temp < -1000) plant_temp = -1000;
        t = plant_temp;
      end else if (pick < 70) begin
        t = tgt + $urandom_range(0, 2 * span) - span;
      end else if (pick < 85) begin
        t = maxt + $urandom_range(0, 200) - 150;
      end else if (pick < 93) begin
        t = $urandom_range(0, 8900) - 900;
      end
    end
    send_item(c, t[15:0], inv);
  endtask

  // Receiver: random ready pattern, or a long hold when asked
  initial begin : drive_ready
    rx_mode_t rx_mode;
    int rx_count;
    m_tready = 1'b0;
    rx_mode  = RX_ALWAYS;
    rx_count = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_count == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          rx_count = $urandom_range(20, 150);
        end
        rx_count--;
        case (rx_mode)
          RX_ALWAYS:        m_tready <= 1'b1;
          RX_COIN:          m_tready <= ($urandom_range(0, 1) == 1);
          RX_THREE_OF_FOUR: m_tready <= (rx_count % 4) != 0;
          default:          m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    hbbg_pkg::result_t want;
    logic [7:0] want_bus;
    string      bad;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("result %0d: got %b with no item pending", results_seen, m_tdata);
      end else begin
        want     = pending_results.pop_front();
        want_bus = {1'b0, want.off_event, want.on_event, want.reached_event,
                    want.changed_event, want.fault_event, want.fault_latched, want.heater_on};
        bad = "";
        for (int i = 0; i < 8; i++)
          if (m_tdata[i] !== want_bus[i]) bad = {bad, " ", field_name[i]};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("result %0d: expected %b got %b, wrong:%s",
                     results_seen, want_bus, m_tdata, bad);
        end
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("heater_bang_bang_guard_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // First sample, threshold edge, 16-bit extremes
  task automatic test_change_detect();
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd0, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd8, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd17, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, -16'sd32768, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd32767, 1'b0);
  endtask

  // Start/stop gating, sensor fault command, invalid readings, clear hysteresis
  task automatic test_relay_and_faults();
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd100, 1'b0);
    send_item(hbbg_pkg::CMD_START, 16'($urandom), 1'b1);
    send_item(hbbg_pkg::CMD_START, 16'($urandom), 1'b0);
    send_item(hbbg_pkg::CMD_STOP, 16'($urandom), 1'b1);
    send_item(hbbg_pkg::CMD_STOP, 16'($urandom), 1'b0);
    send_item(hbbg_pkg::CMD_START, 16'($urandom), 1'b0);
    send_item(hbbg_pkg::CMD_FAULT, 16'($urandom), 1'b1);
    send_item(hbbg_pkg::CMD_START, 16'($urandom), 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd200, 1'b1);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd200, 1'b1);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd3920, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd3919, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, -16'sd800, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, -16'sd801, 1'b0);
  endtask

  // Band control: heat, reach once, cut off above, re-approach, re-arm by write
  task automatic test_control_band();
    reg_write(hbbg_pkg::REG_TARGET, 32'd400);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'd16);
    reg_write(hbbg_pkg::REG_TARGET_EN, 32'd1);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd100, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd384, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd400, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd416, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd383, 1'b0);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd390, 1'b0);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'd16);
    send_item(hbbg_pkg::CMD_SAMPLE, 16'sd395, 1'b0);
  endtask

  // Register extremes, out-of-range values, junk upper bits, unmapped index
  task automatic test_register_extremes();
    reg_write(hbbg_pkg::REG_MAX_TEMP, 32'd0);
    reg_write(hbbg_pkg::REG_TARGET, 32'd0);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'd0);
    reg_write(hbbg_pkg::REG_CHANGE_THR, 32'd0);
    plant_temp = 0;
    repeat (30) send_random_item();

    reg_write(hbbg_pkg::REG_MAX_TEMP, 32'hFFFF_FFFF);
    reg_write(hbbg_pkg::REG_TARGET, 32'h0000_1FFF);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'h0000_07FF);
    reg_write(hbbg_pkg::REG_CHANGE_THR, 32'hFFFF_FFFF);
    plant_temp = 7000;
    repeat (30) send_random_item();

    reg_write(hbbg_pkg::REG_MAX_TEMP, 32'd8000);
    reg_write(hbbg_pkg::REG_TARGET, 32'hFFFF_E000);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'hFFFF_F800);
    reg_write(hbbg_pkg::REG_CHANGE_THR, 32'h0000_0800);
    plant_temp = -700;
    repeat (30) send_random_item();

    reg_write(REG_SPARE, $urandom);
    reg_write(hbbg_pkg::REG_MAX_TEMP, 32'hABCD_EFA0);
    reg_write(hbbg_pkg::REG_TARGET, 32'd400);
    reg_write(hbbg_pkg::REG_TOLERANCE, 32'd1600);
    reg_write(hbbg_pkg::REG_TARGET_EN, 32'hFFFF_FFFE);
    reg_write(hbbg_pkg::REG_CHANGE_THR, 32'd1600);
    plant_temp = 400;
    repeat (30) send_random_item();
  endtask

  // Random phases, each with its own register setting
  task automatic test_random_traffic();
    int tgt, span;
    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(0, 4) == 0) reg_write(hbbg_pkg::REG_MAX_TEMP, $urandom_range(0, 8191));
      else reg_write(hbbg_pkg::REG_MAX_TEMP, $urandom_range(1500, 8000));
      tgt = $urandom_range(0, 4000) - 800;
      if (tgt > int'(cfg.max_temp) - 100) tgt = cfg.max_temp / 2;
      if (phase == 5) tgt = cfg.max_temp + 50;
      reg_write(hbbg_pkg::REG_TARGET, tgt);
      if ($urandom_range(0, 5) == 0) reg_write(hbbg_pkg::REG_TOLERANCE, $urandom_range(0, 2047));
      else reg_write(hbbg_pkg::REG_TOLERANCE, $urandom_range(0, 100));
      reg_write(hbbg_pkg::REG_TARGET_EN, 32'($urandom_range(0, 9) != 0));
      if ($urandom_range(0, 5) == 0)
        reg_write(hbbg_pkg::REG_CHANGE_THR, $urandom_range(0, 2047));
      else reg_write(hbbg_pkg::REG_CHANGE_THR, $urandom_range(0, 40));
      span = 2 * int'(cfg.tolerance) + 40;
      plant_temp = $signed(cfg.target_temp) - span;
      free_run = (phase % 3 == 0);
      repeat (210) send_random_item();
      free_run = 1'b0;
    end
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    hold_len = 80;
    hold_req = 1'b1;
    free_run = 1'b1;
    repeat (40) send_random_item();
    free_run = 1'b0;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg.max_temp         = hbbg_pkg::MAX_TEMP_RST;
    cfg.target_temp      = hbbg_pkg::TARGET_RST;
    cfg.tolerance        = hbbg_pkg::TOLERANCE_RST;
    cfg.target_enable    = 1'b0;
    cfg.change_threshold = hbbg_pkg::CHANGE_THR_RST;
    last_temp = '0;
    have_last = 1'b0;
    fault_q   = 1'b0;
    relay_q   = 1'b0;
    reached_q = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_change_detect();
    test_relay_and_faults();
    test_control_band();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("heater_bang_bang_guard_unit_test passed");
    end else begin
      $display("heater_bang_bang_guard_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hbbg_pkg.sv
rtl/hbbg_core.sv
rtl/heater_bang_bang_guard_unit.sv
rtl/hbbg_checker.sv
dv/heater_bang_bang_guard_unit_test.sv
